// ===== rtl/xor_parity_fec_receiver_unit_defines.svh =====
// Assertion macros for the XOR parity FEC receiver.
// Depends on nothing; the using module must have clock and reset in scope.
`ifndef XOR_PARITY_FEC_RECEIVER_UNIT_DEFINES_SVH
`define XOR_PARITY_FEC_RECEIVER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FEC_ASSERT_IMP(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("fec_rx assertion failed");
`define FEC_ASSERT_NXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("fec_rx assertion failed");
`else
`define FEC_ASSERT_IMP(name, cond, prop)
`define FEC_ASSERT_NXT(name, cond, prop)
`endif
`endif

// ===== rtl/fec_rx_pkg.sv =====
// Shared types and constants of the XOR parity FEC receiver.
// Used by every module of the block but fec_rx_ram; depends on nothing.
package fec_rx_pkg;
   localparam int GROUP_SIZE    = 4;
   localparam int PAYLOAD_WORDS = 8;
   localparam int NUM_GROUPS    = 256;

   localparam int FRAME_DEPTH = NUM_GROUPS * GROUP_SIZE;
   localparam int ACC_DEPTH   = NUM_GROUPS * PAYLOAD_WORDS;
   localparam int ACC_AW      = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam int GRP_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int GIDX_W      = $clog2(GROUP_SIZE);
   localparam int GCNT_W      = $clog2(GROUP_SIZE + 1);
   localparam int WPOS_W      = $clog2(PAYLOAD_WORDS + 1);

   localparam int FLIM_W  = 11;
   localparam int GLIM_W  = 9;
   localparam int OSEQ_W  = 10;
   localparam int CSR_IW  = 1;
   localparam int CSR_DW  = 11;

   localparam logic [CSR_IW-1:0] CSR_FRAME_LIMIT = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_GROUP_LIMIT = 1'b1;

   typedef struct packed {
      logic        is_parity;
      logic [31:0] seq;
      logic [15:0] group;
      logic [63:0] payload_word;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [OSEQ_W-1:0] out_seq;
      logic [63:0]       out_word;
      logic              out_last;
      logic              out_recovered;
   } rsp_type;

   // per-group bookkeeping: parity, done, and per-frame seen/sent flags
   typedef struct packed {
      logic                  parity_seen;
      logic                  group_done;
      logic [GROUP_SIZE-1:0] seen;
      logic [GROUP_SIZE-1:0] sent;
   } meta_type;

   localparam int META_W = $bits(meta_type);

   typedef struct packed {
      logic clear;
      logic accept;
      logic hdr;
      logic acc_step;
      logic check;
      logic burst_step;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic in_packet;
      logic out_free;
      logic fwd_pending;
      logic last;
      logic rebuild_emit;
      logic burst_last;
   } sts_type;
endpackage

// ===== rtl/fec_rx_ram.sv =====
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
module fec_rx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/fec_rx_ctrl.sv =====
// Controller state machine of the FEC receiver.
// Depends on fec_rx_pkg; drives commands to fec_rx_dpath.
module fec_rx_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fec_rx_pkg::sts_type sts,
   output fec_rx_pkg::cmd_type cmd
);
   import fec_rx_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HDR   = 6'b000100,
      S_ACC   = 6'b001000,
      S_CHECK = 6'b010000,
      S_BURST = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.in_packet ? S_ACC : S_HDR;
            end
         end
         S_HDR: begin
            cmd.hdr  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            // hold the word while the forward slot is taken
            if (!sts.fwd_pending || sts.out_free) begin
               cmd.acc_step = 1'b1;
               state_in     = sts.last ? S_CHECK : S_IDLE;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.rebuild_emit ? S_BURST : S_IDLE;
         end
         S_BURST: begin
            if (sts.out_free) begin
               cmd.burst_step = 1'b1;
               if (sts.burst_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
endmodule

// ===== rtl/fec_rx_dpath.sv =====
// Datapath of the FEC receiver: limits, group bookkeeping RAM, XOR accumulator
// RAM, packet state and output register. Depends on fec_rx_pkg and fec_rx_ram.
`include "xor_parity_fec_receiver_unit_defines.svh"
module fec_rx_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [fec_rx_pkg::CSR_IW-1:0]  csr_index,
   input  logic [fec_rx_pkg::CSR_DW-1:0]  csr_wdata,
   input  fec_rx_pkg::req_type            req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fec_rx_pkg::rsp_type            rsp_payload,
   input  fec_rx_pkg::cmd_type            cmd,
   output fec_rx_pkg::sts_type            sts
);
   import fec_rx_pkg::*;

   logic [FLIM_W-1:0] flim_ff;
   logic [GLIM_W-1:0] glim_ff;
   logic [ACC_AW-1:0] clr_ff;

   logic [63:0] word_ff;
   logic        last_ff, par_ff;
   logic [31:0] seq_ff;
   logic [15:0] grp_ff;

   logic              in_pkt_ff, mode_ok_ff, mode_fwd_ff, mode_acc_ff;
   logic [WPOS_W-1:0] wpos_ff;
   logic [OSEQ_W-1:0] pkt_seq_ff, bseq_ff;
   logic [GRP_W-1:0]  pkt_grp_ff;
   logic [WPOS_W-1:0] bcnt_ff;
   meta_type          meta_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;

   logic [31:0] eff_frames;
   logic [16:0] eff_groups;

   meta_type        meta_rd, hdr_meta, chk_meta, meta_wdata;
   logic            g_ok, hdr_ok, hdr_fwd, hdr_acc;
   logic [31:0]     base, diff;
   logic [GIDX_W-1:0] idx;

   logic [GCNT_W-1:0] seen_cnt;
   logic [GIDX_W-1:0] miss;
   logic [31:0]       miss_seq;
   logic              elig, emit;

   logic              meta_we;
   logic [GRP_W-1:0]  meta_waddr;

   logic              acc_we, acc_re;
   logic [ACC_AW-1:0] acc_waddr, acc_raddr;
   logic [63:0]       acc_wdata, acc_rd;

   logic    word_in_range, fwd_push, pop, out_free;
   rsp_type out_in;

   function automatic logic [ACC_AW-1:0] acc_addr(input logic [GRP_W-1:0] g,
                                                   input logic [WPOS_W-1:0] w);
      logic [ACC_AW+WPOS_W:0] a;
      a = (ACC_AW+WPOS_W+1)'(g) * (ACC_AW+WPOS_W+1)'(PAYLOAD_WORDS)
        + (ACC_AW+WPOS_W+1)'(w);
      return a[ACC_AW-1:0];
   endfunction

   assign eff_frames = (32'(flim_ff) < 32'(FRAME_DEPTH)) ? 32'(flim_ff) : 32'(FRAME_DEPTH);
   assign eff_groups = (17'(glim_ff) < 17'(NUM_GROUPS)) ? 17'(glim_ff) : 17'(NUM_GROUPS);

   // header decision on the first word of a packet
   always_comb begin
      hdr_meta = meta_rd;
      hdr_ok   = 1'b0;
      hdr_fwd  = 1'b0;
      hdr_acc  = 1'b0;
      g_ok     = 17'(grp_ff) < eff_groups;
      base     = 32'(grp_ff) * 32'(GROUP_SIZE);
      diff     = seq_ff - base;
      idx      = diff[GIDX_W-1:0];
      if (g_ok) begin
         if (par_ff) begin
            hdr_ok = 1'b1;
            if (!meta_rd.parity_seen) begin
               hdr_meta.parity_seen = 1'b1;
               hdr_acc              = 1'b1;
            end
         end else if (seq_ff < eff_frames && seq_ff >= base &&
                      diff < 32'(GROUP_SIZE)) begin
            hdr_ok = 1'b1;
            if (!meta_rd.sent[idx]) begin
               hdr_meta.sent[idx] = 1'b1;
               hdr_fwd            = 1'b1;
            end
            if (!meta_rd.seen[idx]) begin
               hdr_meta.seen[idx] = 1'b1;
               hdr_acc            = 1'b1;
            end
         end
      end
   end

   // recovery check at the end of a packet
   always_comb begin
      seen_cnt = '0;
      miss     = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         seen_cnt = seen_cnt + GCNT_W'(meta_ff.seen[i]);
         if (!meta_ff.seen[i]) miss = GIDX_W'(i);
      end
      elig = mode_ok_ff && !meta_ff.group_done && meta_ff.parity_seen &&
             seen_cnt == GCNT_W'(GROUP_SIZE - 1);
      miss_seq = 32'(pkt_grp_ff) * 32'(GROUP_SIZE) + 32'(miss);
      emit     = elig && miss_seq < eff_frames && !meta_ff.sent[miss];
      chk_meta = meta_ff;
      chk_meta.group_done = 1'b1;
      if (emit) chk_meta.sent[miss] = 1'b1;
   end

   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = pkt_grp_ff;
      meta_wdata = chk_meta;
      if (cmd.clear) begin
         meta_we    = 32'(clr_ff) < 32'(NUM_GROUPS);
         meta_waddr = clr_ff[GRP_W-1:0];
         meta_wdata = '0;
      end else if (cmd.hdr) begin
         meta_we    = hdr_ok;
         meta_waddr = grp_ff[GRP_W-1:0];
         meta_wdata = hdr_meta;
      end else if (cmd.check) begin
         meta_we = elig;
      end
   end

   fec_rx_ram #(.WIDTH(META_W), .DEPTH(NUM_GROUPS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (req_payload.group[GRP_W-1:0]),
      .rd_data (meta_rd)
   );

   assign word_in_range = wpos_ff < WPOS_W'(PAYLOAD_WORDS);
   assign fwd_push      = cmd.acc_step && mode_fwd_ff && word_in_range;

   always_comb begin
      acc_we    = 1'b0;
      acc_waddr = acc_addr(pkt_grp_ff, wpos_ff);
      acc_wdata = acc_rd ^ word_ff;
      if (cmd.clear) begin
         acc_we    = 1'b1;
         acc_waddr = clr_ff;
         acc_wdata = '0;
      end else if (cmd.acc_step) begin
         acc_we = mode_acc_ff && word_in_range;
      end
   end

   always_comb begin
      acc_re    = 1'b0;
      acc_raddr = acc_addr(pkt_grp_ff, '0);
      if (cmd.accept) begin
         acc_re    = in_pkt_ff;
         acc_raddr = acc_addr(pkt_grp_ff, wpos_ff);
      end else if (cmd.hdr) begin
         acc_re    = 1'b1;
         acc_raddr = acc_addr(grp_ff[GRP_W-1:0], '0);
      end else if (cmd.check) begin
         acc_re = emit;
      end else if (cmd.burst_step) begin
         acc_re    = !sts.burst_last;
         acc_raddr = acc_addr(pkt_grp_ff, bcnt_ff + 1'b1);
      end
   end

   fec_rx_ram #(.WIDTH(64), .DEPTH(ACC_DEPTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_en   (acc_re),
      .rd_addr (acc_raddr),
      .rd_data (acc_rd)
   );

   assign pop      = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_in = out_ff;
      if (cmd.burst_step) begin
         out_in.out_seq       = bseq_ff;
         out_in.out_word      = acc_rd;
         out_in.out_last      = sts.burst_last;
         out_in.out_recovered = 1'b1;
      end else if (fwd_push) begin
         out_in.out_seq       = pkt_seq_ff;
         out_in.out_word      = word_ff;
         out_in.out_last      = last_ff || wpos_ff == WPOS_W'(PAYLOAD_WORDS - 1);
         out_in.out_recovered = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flim_ff      <= FLIM_W'(1024);
         glim_ff      <= GLIM_W'(256);
         clr_ff       <= '0;
         in_pkt_ff    <= 1'b0;
         mode_ok_ff   <= 1'b0;
         mode_fwd_ff  <= 1'b0;
         mode_acc_ff  <= 1'b0;
         wpos_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_LIMIT: flim_ff <= csr_wdata[FLIM_W-1:0];
               CSR_GROUP_LIMIT: glim_ff <= csr_wdata[GLIM_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.hdr) begin
            mode_ok_ff  <= hdr_ok;
            mode_fwd_ff <= hdr_fwd;
            mode_acc_ff <= hdr_acc;
            wpos_ff     <= '0;
         end
         if (cmd.acc_step) begin
            if (last_ff) begin
               in_pkt_ff <= 1'b0;
               wpos_ff   <= '0;
            end else begin
               in_pkt_ff <= 1'b1;
               if (word_in_range) wpos_ff <= wpos_ff + 1'b1;
            end
         end
         if (cmd.check) begin
            mode_ok_ff  <= 1'b0;
            mode_fwd_ff <= 1'b0;
            mode_acc_ff <= 1'b0;
         end
         out_valid_ff <= cmd.burst_step || fwd_push || (out_valid_ff && !pop);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         word_ff <= req_payload.payload_word;
         last_ff <= req_payload.last_word;
         par_ff  <= req_payload.is_parity;
         seq_ff  <= req_payload.seq;
         grp_ff  <= req_payload.group;
      end
      if (cmd.hdr) begin
         meta_ff    <= hdr_meta;
         pkt_grp_ff <= grp_ff[GRP_W-1:0];
         pkt_seq_ff <= seq_ff[OSEQ_W-1:0];
      end
      if (cmd.check) begin
         if (elig) meta_ff <= chk_meta;
         bseq_ff <= miss_seq[OSEQ_W-1:0];
         bcnt_ff <= '0;
      end
      if (cmd.burst_step) bcnt_ff <= bcnt_ff + 1'b1;
      out_ff <= out_in;
   end

   always_comb begin
      sts.clear_done   = clr_ff == ACC_AW'(ACC_DEPTH - 1);
      sts.in_packet    = in_pkt_ff;
      sts.out_free     = out_free;
      sts.fwd_pending  = mode_fwd_ff && word_in_range;
      sts.last         = last_ff;
      sts.rebuild_emit = emit;
      sts.burst_last   = bcnt_ff == WPOS_W'(PAYLOAD_WORDS - 1);
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `FEC_ASSERT_IMP(a_burst_slot_free, cmd.burst_step, out_free)
   `FEC_ASSERT_IMP(a_fwd_slot_free, fwd_push, out_free)
   `FEC_ASSERT_IMP(a_acc_needs_ok, cmd.acc_step && mode_acc_ff, mode_ok_ff)
   `FEC_ASSERT_NXT(a_burst_starts_at_zero, cmd.check && emit, bcnt_ff == '0)
endmodule

// ===== rtl/xor_parity_fec_receiver_unit.sv =====
// XOR parity FEC receiver: top level joining controller and datapath.
// Depends on fec_rx_pkg, fec_rx_ctrl and fec_rx_dpath.
//
// After reset the block sweeps all NUM_GROUPS * PAYLOAD_WORDS entries (2048)
// of its accumulator memory and keeps req_stall high; configuration writes
// are taken during that sweep. Each payload word then goes through an
// accumulator read-modify-write, with req_stall high until it is done; the
// first word of a packet also reads the group bookkeeping, the last word is
// followed by the recovery check, and a recovery emits PAYLOAD_WORDS words.
// A stalled result holds the next forwarded word back.
module xor_parity_fec_receiver_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fec_rx_pkg::CSR_IW-1:0] csr_index,
   input  logic [fec_rx_pkg::CSR_DW-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fec_rx_pkg::req_type           req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fec_rx_pkg::rsp_type           rsp_payload
);
   import fec_rx_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fec_rx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fec_rx_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the XOR parity FEC receiver unit: directed and random packets.
// Depends on fec_rx_pkg and xor_parity_fec_receiver_unit; predicts results in-line.
module tb_top;
   import fec_rx_pkg::*;

   localparam int SLACK = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   xor_parity_fec_receiver_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [10:0] frame_lim;
   logic [8:0]  group_lim;
   bit          sent_q[FRAME_DEPTH];
   bit          seen_q[FRAME_DEPTH];
   bit          par_q[NUM_GROUPS];
   int          rx_cnt[NUM_GROUPS];
   bit          done_q[NUM_GROUPS];
   logic [63:0] acc_q[NUM_GROUPS*PAYLOAD_WORDS];
   bit          mid_pkt;
   bit          m_fwd, m_acc, m_ok;
   int          wpos;
   int          cur_seq, cur_grp;

   rsp_type     frames_due[$];
   int          errors = 0;
   int          n_checked = 0;
   int          n_recovered = 0;
   int          n_sent = 0;
   longint      cycles = 0;
   bit          quiet_rx = 1'b0;
   bit          quiet_tx = 1'b0;

   task automatic report(string what);
      errors++;
      $display("MISMATCH @%0d: %s", cycles, what);
   endtask

   function automatic int eff_frames();
      return (frame_lim < FRAME_DEPTH) ? int'(frame_lim) : FRAME_DEPTH;
   endfunction

   function automatic int eff_groups();
      return (group_lim < NUM_GROUPS) ? int'(group_lim) : NUM_GROUPS;
   endfunction

   function automatic void push_frame(int s, logic [63:0] w, bit lst, bit rec);
      rsp_type r;
      r.out_seq = s[OSEQ_W-1:0];
      r.out_word = w;
      r.out_last = lst;
      r.out_recovered = rec;
      frames_due.push_back(r);
   endfunction

   function automatic void open_packet(req_type p);
      m_fwd = 0; m_acc = 0; m_ok = 0;
      if (p.group >= eff_groups()) return;
      cur_grp = p.group;
      if (p.is_parity) begin
         m_ok = 1;
         if (!par_q[p.group]) begin
            par_q[p.group] = 1;
            m_acc = 1;
         end
         return;
      end
      if (p.seq >= eff_frames()) return;
      if (p.seq / GROUP_SIZE != p.group) return;
      cur_seq = p.seq;
      m_ok = 1;
      if (!sent_q[p.seq]) begin
         sent_q[p.seq] = 1;
         m_fwd = 1;
      end
      if (!seen_q[p.seq]) begin
         seen_q[p.seq] = 1;
         rx_cnt[p.group]++;
         m_acc = 1;
      end
   endfunction

   function automatic void check_rebuild();
      int g = cur_grp;
      int miss = 0;
      bit found = 0;
      if (done_q[g] || !par_q[g] || rx_cnt[g] != GROUP_SIZE - 1) return;
      for (int i = 0; i < GROUP_SIZE; i++)
         if (!seen_q[g*GROUP_SIZE+i]) begin
            miss = i;
            found = 1;
         end
      if (!found) return;
      done_q[g] = 1;
      miss += g * GROUP_SIZE;
      if (miss >= eff_frames() || sent_q[miss]) return;
      sent_q[miss] = 1;
      for (int i = 0; i < PAYLOAD_WORDS; i++)
         push_frame(miss, acc_q[g*PAYLOAD_WORDS+i], i == PAYLOAD_WORDS - 1, 1);
   endfunction

   function automatic void predict_word(req_type p);
      if (!mid_pkt) begin
         wpos = 0;
         open_packet(p);
      end
      if (wpos < PAYLOAD_WORDS) begin
         if (m_acc) acc_q[cur_grp*PAYLOAD_WORDS+wpos] ^= p.payload_word;
         if (m_fwd)
            push_frame(cur_seq, p.payload_word, p.last_word || wpos == PAYLOAD_WORDS - 1, 0);
         wpos++;
      end
      if (p.last_word) begin
         if (m_ok) check_rebuild();
         mid_pkt = 0; m_fwd = 0; m_acc = 0; m_ok = 0; wpos = 0;
      end else begin
         mid_pkt = 1;
      end
   endfunction

   // result checking and receiver stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               report($sformatf("unexpected result seq %0d", rsp_payload.out_seq));
            end else begin
               rsp_type e;
               e = frames_due.pop_front();
               n_checked++;
               if (rsp_payload.out_recovered) n_recovered++;
               if (rsp_payload.out_seq !== e.out_seq)
                  report($sformatf("out_seq %0d exp %0d", rsp_payload.out_seq, e.out_seq));
               if (rsp_payload.out_word !== e.out_word)
                  report($sformatf("out_word %h exp %h", rsp_payload.out_word, e.out_word));
               if (rsp_payload.out_last !== e.out_last)
                  report($sformatf("out_last %b exp %b", rsp_payload.out_last, e.out_last));
               if (rsp_payload.out_recovered !== e.out_recovered)
                  report($sformatf("out_recovered %b exp %b",
                     rsp_payload.out_recovered, e.out_recovered));
            end
         end
         rsp_stall <= quiet_rx ? 1'b0 : ($urandom_range(99) < 6);
      end
      if (cycles > 3000000) begin
         $display("timeout waiting on results");
         $display("tb_top failed");
         $finish;
      end
   end

   // valid stays up after a transfer until the next word or an idle cycle replaces it
   task automatic send_word(req_type p);
      while (!quiet_tx && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(p);
      n_sent++;
   endtask

   task automatic send_packet(int par, logic [31:0] s, int g, int nwords,
                              bit scramble_hdr = 0);
      req_type p;
      for (int i = 0; i < nwords; i++) begin
         p.is_parity = 1'(par);
         p.seq = s;
         p.group = 16'(g);
         if (scramble_hdr && i > 0) begin
            p.is_parity = 1'($urandom);
            p.seq = $urandom;
            p.group = 16'($urandom);
         end
         p.payload_word = {$urandom, $urandom};
         p.last_word = (i == nwords - 1);
         send_word(p);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SLACK) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DW-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_FRAME_LIMIT) frame_lim = val[10:0];
      else group_lim = val[8:0];
   endtask

   // whole group of GROUP_SIZE data frames, one held back, plus parity
   task automatic send_group(int g, int lose, int nwords);
      for (int i = 0; i < GROUP_SIZE; i++)
         if (i != lose) send_packet(0, g*GROUP_SIZE + i, g, nwords);
      send_packet(1, $urandom, g, nwords);
   endtask

   task automatic test_directed();
      send_group(0, 2, PAYLOAD_WORDS);
      send_packet(0, 1, 0, PAYLOAD_WORDS);           // duplicate after recovery
      send_packet(0, 8, 1, 3);                       // short packet
      send_packet(0, 9, 1, 11, 1);                   // long, junk header after first
      send_packet(1, 0, 1, 1);                       // parity
      send_packet(0, 11, 1, PAYLOAD_WORDS);          // wrong group, dropped
      send_packet(0, 20, 4, 2);                      // wrong group, dropped
      send_packet(0, 32'hFFFF_FFFF, 16'hFFFF, 2);    // out of range
      send_packet(1, 0, 16'hFFFF, 1);                // parity group out of range
      send_packet(0, 1023, 255, PAYLOAD_WORDS);      // top frame
      drain();
   endtask

   task automatic test_limits();
      write_reg(CSR_FRAME_LIMIT, 0);
      write_reg(CSR_GROUP_LIMIT, 0);
      send_packet(0, 40, 10, 2);
      send_packet(1, 0, 10, 2);
      drain();
      write_reg(CSR_FRAME_LIMIT, 50);
      write_reg(CSR_GROUP_LIMIT, 13);
      send_group(12, 3, 4);                          // missing frame 51 beyond limit
      send_group(11, 1, PAYLOAD_WORDS);
      drain();
      write_reg(CSR_FRAME_LIMIT, 2047);              // saturates
      write_reg(CSR_GROUP_LIMIT, 511);
      send_group(200, 0, PAYLOAD_WORDS);
      drain();
      // pause until idle, then flat out with no stalls
      quiet_tx = 1; quiet_rx = 1;
      send_group(201, 3, PAYLOAD_WORDS);
      send_group(202, 1, 5);
      drain();
      quiet_tx = 0; quiet_rx = 0;
   endtask

   task automatic test_random(int budget);
      int g, lose, nw;
      while (n_sent < budget) begin
         case ($urandom_range(9))
            0: send_packet($urandom, $urandom, $urandom, $urandom_range(1, 3));
            1: begin
               g = $urandom_range(NUM_GROUPS - 1);
               send_packet(0, g*GROUP_SIZE + $urandom_range(GROUP_SIZE - 1), g,
                           $urandom_range(1, 10), 1);
            end
            default: begin
               g = $urandom_range(NUM_GROUPS - 1);
               lose = $urandom_range(GROUP_SIZE - 1);
               nw = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : PAYLOAD_WORDS;
               for (int i = 0; i < GROUP_SIZE; i++)
                  if (i != lose || $urandom_range(7) == 0)
                     send_packet(0, g*GROUP_SIZE + i, g, nw);
               if ($urandom_range(7) != 0) send_packet(1, $urandom, g, nw);
            end
         endcase
      end
      drain();
   endtask

   initial begin
      frame_lim = 11'd1024;
      group_lim = 9'd256;
      foreach (acc_q[i]) acc_q[i] = '0;
      mid_pkt = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      write_reg(CSR_FRAME_LIMIT, 1024);
      write_reg(CSR_GROUP_LIMIT, 256);
      test_random(n_sent + 110);
      $display("covered %0d words in, %0d results checked, %0d recovered",
               n_sent, n_checked, n_recovered);
      $display("limits swept from zero to saturation, drops and duplicates included");
      if (errors == 0 && frames_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule

// ===== xor_parity_fec_receiver_unit.f =====
+incdir+rtl
rtl/fec_rx_pkg.sv
rtl/fec_rx_ram.sv
rtl/fec_rx_ctrl.sv
rtl/fec_rx_dpath.sv
rtl/xor_parity_fec_receiver_unit.sv
tb/sv/tb_top.sv
